// File: rtl/core/sgcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcv_pkg
// Shared types and constants for the step sequencer with CV and gate outputs.
// ----------------------------------------------------------------------------
package sgcv_pkg;

  // default design sizes
  localparam int STEP_COUNT_DEF = 16;
  localparam int DAC_BITS_DEF   = 12;

  // timing constants
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [15:0] DEFAULT_BPM   = 16'd120;
  localparam logic [7:0]  DEFAULT_SPB   = 8'd4;

  // divider widths
  localparam int PROD_W = 24;
  localparam int QUOT_W = 16;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMPO_BPM      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_BEAT = 8'd1;

  // reset table of step voltages, repeats every sixteen steps
  localparam logic [11:0] SEED_VALUES [16] = '{
    12'd0,    12'd1024, 12'd2048, 12'd3072,
    12'd512,  12'd1536, 12'd2560, 12'd3584,
    12'd768,  12'd1792, 12'd2816, 12'd3840,
    12'd256,  12'd1280, 12'd2304, 12'd3328
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } seq_state_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/sgcv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcv_div
// Radix-2 restoring divider: ms per minute over the step rate, one quotient
// bit per cycle through a single shared compare and subtract.
// ----------------------------------------------------------------------------
module sgcv_div
  import sgcv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy;
  logic [CNT_W-1:0]  bit_idx;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] divisor;
  logic [QUOT_W-1:0] quot;
  logic              done;

  logic [PROD_W:0]   trial;
  logic              fits;
  logic [PROD_W:0]   diff;

  // shared compare and subtract
  always_comb begin
    trial = {rem, MS_PER_MINUTE[bit_idx]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_idx <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_idx <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quot    <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// File: rtl/core/step_sequencer_gate_cv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_gate_cv
// Step sequencer with CV and gate outputs, one input word per millisecond.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick with the sampled button level and
// yields exactly one output word with the current step's CV code, its gate,
// the LED index of the following step and a flag set when the outputs
// changed. A rising button edge toggles the current step's gate enable; the
// step advances when the tick count reaches 60000 / (bpm * steps per beat),
// at least 1 (zero bpm means 120, zero steps per beat means 4). A tick goes
// through the multiply, divide, wait and output states from acceptance to
// its output word, while the restoring divider recomputes the step period;
// the input side is not ready during that time. The output word sits in a
// register, so the next tick is accepted while it waits. Configuration
// writes are always taken and must only happen while no tick is in flight.
module step_sequencer_gate_cv
  import sgcv_pkg::*;
#(
  parameter int STEP_COUNT = STEP_COUNT_DEF,
  parameter int DAC_BITS   = DAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [0] button_pressed
  // output words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [11:0] cv_value, [23:12] gate_value,
                                            // [27:24] led_index, [28] outputs_updated
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(STEP_COUNT - 1);
  localparam logic [15:0] DAC_FULL = 16'((32'd1 << DAC_BITS) - 32'd1);

  // configuration registers
  logic [15:0] tempo_bpm;
  logic [7:0]  steps_per_beat;

  // sequencer state
  seq_state_t      state, state_next;
  logic [STEP_COUNT-1:0] step_enables;
  logic [SW-1:0]   current_step;
  logic [15:0]     elapsed_ticks;
  logic            button_was_pressed;
  logic            outputs_dirty;
  logic [PROD_W-1:0] product;
  logic [15:0]     period;

  // output register
  logic            out_valid;
  logic [31:0]     out_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            in_fire;
  logic            pressed;
  logic            out_load;
  logic            advance;
  logic [SW-1:0]   step_inc;
  logic [SW-1:0]   new_step;
  logic [SW-1:0]   led_step;
  logic [7:0]      new_wide;
  logic [7:0]      led_wide;
  logic [15:0]     bpm_eff;
  logic [7:0]      spb_eff;
  logic [15:0]     cv_wide;
  logic [11:0]     cv_value;
  logic [11:0]     gate_value;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign pressed   = s_tdata[0];
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_bpm      <= DEFAULT_BPM;
      steps_per_beat <= DEFAULT_SPB;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TEMPO_BPM) begin
        tempo_bpm <= cfg_data;
      end else if (cfg_index == REG_STEPS_PER_BEAT) begin
        steps_per_beat <= cfg_data[7:0];
      end
    end
  end

  // substitute defaults for zero settings
  assign bpm_eff = (tempo_bpm == '0) ? DEFAULT_BPM : tempo_bpm;
  assign spb_eff = (steps_per_beat == '0) ? DEFAULT_SPB : steps_per_beat;

  // step arithmetic for the output stage
  always_comb begin
    advance  = elapsed_ticks >= period;
    step_inc = (current_step == LAST_STEP) ? '0 : current_step + 1'b1;
    new_step = advance ? step_inc : current_step;
    led_step = (new_step == LAST_STEP) ? '0 : new_step + 1'b1;
    new_wide = 8'(new_step);
    led_wide = 8'(led_step);
    cv_wide  = 16'(SEED_VALUES[new_wide[3:0]]) & DAC_FULL;
    cv_value = cv_wide[11:0];
    gate_value = step_enables[new_step] ? DAC_FULL[11:0] : 12'd0;
  end

  // divider hookup
  assign div_req.start   = (state == ST_DIV);
  assign div_req.divisor = product;

  sgcv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // step state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_enables       <= '1;
      current_step       <= '0;
      elapsed_ticks      <= '0;
      button_was_pressed <= 1'b0;
      outputs_dirty      <= 1'b1;
    end else begin
      if (in_fire) begin
        // button edge toggles the current step, tick count saturates
        if (pressed && !button_was_pressed) begin
          step_enables[current_step] <= ~step_enables[current_step];
          outputs_dirty <= 1'b1;
        end
        button_was_pressed <= pressed;
        if (elapsed_ticks != 16'hFFFF) begin
          elapsed_ticks <= elapsed_ticks + 1'b1;
        end
      end
      if (out_load) begin
        if (advance) begin
          elapsed_ticks <= '0;
          current_step  <= new_step;
        end
        outputs_dirty <= 1'b0;
      end
    end
  end

  // step rate product and period
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      product <= PROD_W'(bpm_eff) * PROD_W'(spb_eff);
    end
    if (state == ST_WAIT && div_rsp.done) begin
      period <= (div_rsp.quotient == '0) ? 16'd1 : div_rsp.quotient;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {3'b000, outputs_dirty || advance, led_wide[3:0], gate_value, cv_value};
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the step sequencer with CV and gate outputs.
// ----------------------------------------------------------------------------
// A short table of directed ticks and register writes checks the reset
// state, button toggles, a held button, the fastest and slowest tempo and
// ignored register indexes. Then random phases follow: each retunes the tempo
// and then sends a run of ticks with pressed and held button patterns. A
// behavioral sequencer inside the bench predicts every output word, and each
// word from the block is compared field by field in arrival order. Both stream
// sides stall at random, except during one phase that runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import sgcv_pkg::*;

  localparam int          RANDOM_TICKS  = 1400;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int          REPORT_LIMIT  = 10;
  localparam logic [11:0] GATE_FULL     = 12'hFFF;
  localparam logic [11:0] GATE_OFF      = 12'h000;

  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 8'hFF;

  // one output word, laid out as on m_tdata
  typedef struct packed {
    logic        updated;
    logic [3:0]  led;
    logic [11:0] gate;
    logic [11:0] cv;
  } cv_gate_t;

  typedef enum logic {
    ROW_TICK,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    val;
    logic                     typed;
    cv_gate_t                 want;
  } row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = 8'd0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [31:0]            m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  step_sequencer_gate_cv dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer state of the bench's own copy
  logic        gate_on [16];
  logic [3:0]  play_step;
  logic [15:0] tick_count;
  logic        button_prev;
  logic        refresh;
  logic [15:0] bpm_setting;
  logic [7:0]  spb_setting;

  cv_gate_t    due_words [$];
  row_t        directed_rows [$];
  int          mismatch_count = 0;
  int          ticks_sent     = 0;
  int          writes_done    = 0;
  int          toggles_seen   = 0;
  int          advances_seen  = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               due_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side stalls
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 24);
  end

  // ticks between step advances for the current tempo
  function automatic int unsigned step_period();
    int unsigned bpm;
    int unsigned spb;
    int unsigned quot;
    bpm  = (bpm_setting == 16'd0) ? int'(DEFAULT_BPM) : int'(bpm_setting);
    spb  = (spb_setting == 8'd0) ? int'(DEFAULT_SPB) : int'(spb_setting);
    quot = int'(MS_PER_MINUTE) / (bpm * spb);
    return (quot == 0) ? 1 : quot;
  endfunction

  function automatic void clear_sequencer();
    for (int i = 0; i < 16; i++) gate_on[i] = 1'b1;
    play_step   = 4'd0;
    tick_count  = 16'd0;
    button_prev = 1'b0;
    refresh     = 1'b1;
    bpm_setting = DEFAULT_BPM;
    spb_setting = DEFAULT_SPB;
  endfunction

  // one millisecond tick: button edge, then step timing, then output word
  function automatic cv_gate_t sequence_tick(input logic pressed);
    cv_gate_t w;
    if (pressed && !button_prev) begin
      gate_on[play_step] = ~gate_on[play_step];
      refresh = 1'b1;
      toggles_seen++;
    end
    button_prev = pressed;
    if (tick_count != 16'hFFFF) tick_count++;
    if (tick_count >= step_period()) begin
      tick_count = 16'd0;
      play_step  = play_step + 4'd1;
      refresh    = 1'b1;
      advances_seen++;
    end
    w.cv      = SEED_VALUES[play_step];
    w.gate    = gate_on[play_step] ? GATE_FULL : GATE_OFF;
    w.led     = play_step + 4'd1;
    w.updated = refresh;
    refresh   = 1'b0;
    return w;
  endfunction

  // send one tick word, return the predicted output once it is taken
  task automatic send_tick(input logic pressed, output cv_gate_t predicted);
    logic took;
    if (!steady && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pressed};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    predicted = sequence_tick(pressed);
    ticks_sent++;
  endtask

  // let every due word come out and the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    if (idx == REG_TEMPO_BPM) bpm_setting = val;
    else if (idx == REG_STEPS_PER_BEAT) spb_setting = val[7:0];
    writes_done++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void tick_row(input logic pressed, input logic typed,
                                   input logic [11:0] cv, input logic [11:0] gate,
                                   input logic [3:0] led, input logic updated);
    row_t r;
    r.kind  = ROW_TICK;
    r.idx   = '0;
    r.val   = {15'd0, pressed};
    r.typed = typed;
    r.want  = {updated, led, gate, cv};
    directed_rows.push_back(r);
  endfunction

  function automatic void write_row(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.val   = val;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endfunction

  // output checker, sampled between edges
  always @(negedge clk) begin
    cv_gate_t got;
    cv_gate_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[28:0];
      if (due_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected word cv=%0d gate=%0d led=%0d upd=%0d",
                   got.cv, got.gate, got.led, got.updated);
      end else begin
        want = due_words.pop_front();
        if (got.cv !== want.cv || got.gate !== want.gate || got.led !== want.led ||
            got.updated !== want.updated) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"word mismatch: expected cv=%0d gate=%0d led=%0d upd=%0d, ",
                      "got cv=%0d gate=%0d led=%0d upd=%0d"},
                     want.cv, want.gate, want.led, want.updated,
                     got.cv, got.gate, got.led, got.updated);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    cv_gate_t    predicted;
    row_t        r;
    int          rand_ticks;
    int          phase;
    int          run_len;
    int          run_left;
    logic        level;
    bit          noisy;
    logic [15:0] bpm_pick;
    logic [7:0]  spb_pick;

    clear_sequencer();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset state, toggle, held button, release, toggle back
    tick_row(1'b0, 1'b1, 12'd0, GATE_FULL, 4'd1, 1'b1);
    tick_row(1'b0, 1'b1, 12'd0, GATE_FULL, 4'd1, 1'b0);
    tick_row(1'b1, 1'b1, 12'd0, GATE_OFF,  4'd1, 1'b1);
    tick_row(1'b1, 1'b1, 12'd0, GATE_OFF,  4'd1, 1'b0);
    tick_row(1'b0, 1'b1, 12'd0, GATE_OFF,  4'd1, 1'b0);
    tick_row(1'b1, 1'b1, 12'd0, GATE_FULL, 4'd1, 1'b1);
    // fastest tempo: period one, step moves every tick
    write_row(REG_TEMPO_BPM, 16'hFFFF);
    write_row(REG_STEPS_PER_BEAT, 16'h00FF);
    tick_row(1'b0, 1'b1, 12'd1024, GATE_FULL, 4'd2, 1'b1);
    // toggle lands on the step being left, output shows the next one
    tick_row(1'b1, 1'b1, 12'd2048, GATE_FULL, 4'd3, 1'b1);
    tick_row(1'b1, 1'b0, '0, '0, '0, 1'b0);
    tick_row(1'b0, 1'b0, '0, '0, '0, 1'b0);
    // writes to indexes without a register are dropped
    write_row(REG_UNUSED, 16'h0001);
    write_row(REG_TOP, 16'h0001);
    tick_row(1'b1, 1'b0, '0, '0, '0, 1'b0);
    tick_row(1'b0, 1'b0, '0, '0, '0, 1'b0);
    // zero registers fall back to the default tempo
    write_row(REG_TEMPO_BPM, 16'h0000);
    write_row(REG_STEPS_PER_BEAT, 16'h0000);
    tick_row(1'b1, 1'b0, '0, '0, '0, 1'b0);
    tick_row(1'b0, 1'b0, '0, '0, '0, 1'b0);
    // slowest tempo
    write_row(REG_TEMPO_BPM, 16'h0001);
    write_row(REG_STEPS_PER_BEAT, 16'h0001);
    tick_row(1'b1, 1'b0, '0, '0, '0, 1'b0);
    tick_row(1'b0, 1'b0, '0, '0, '0, 1'b0);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_WRITE) begin
        settle();
        write_reg(r.idx, r.val);
      end else begin
        send_tick(r.val[0], predicted);
        due_words.push_back(r.typed ? r.want : predicted);
      end
    end

    // random phases, each with its own tempo and button style
    rand_ticks = 0;
    phase      = 0;
    level      = 1'b0;
    while (rand_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 4))
        0: begin
          bpm_pick = 16'($urandom_range(1000, 65535));
          spb_pick = 8'($urandom_range(64, 255));
        end
        1: begin
          bpm_pick = 16'($urandom_range(600, 6000));
          spb_pick = 8'($urandom_range(1, 16));
        end
        2: begin
          bpm_pick = 16'($urandom_range(100, 600));
          spb_pick = 8'($urandom_range(1, 8));
        end
        3: begin
          bpm_pick = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(300, 3000));
          spb_pick = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 12));
        end
        default: begin
          bpm_pick = 16'($urandom());
          spb_pick = 8'($urandom());
        end
      endcase
      settle();
      steady = (phase == 2);
      if ($urandom_range(0, 3) == 0)
        write_reg(8'($urandom_range(REG_UNUSED, REG_TOP)), 16'($urandom()));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_TEMPO_BPM, bpm_pick);
        write_reg(REG_STEPS_PER_BEAT, {8'd0, spb_pick});
      end else begin
        write_reg(REG_STEPS_PER_BEAT, {8'd0, spb_pick});
        write_reg(REG_TEMPO_BPM, bpm_pick);
      end

      // presses held for a while, now and then a noisy button
      noisy    = ($urandom_range(0, 3) == 0);
      run_len  = $urandom_range(60, 220);
      run_left = 0;
      for (int n = 0; n < run_len; n++) begin
        if (run_left == 0) begin
          level    = noisy ? 1'($urandom_range(0, 1)) : ~level;
          run_left = $urandom_range(1, noisy ? 2 : 12);
        end
        run_left--;
        send_tick(level, predicted);
        due_words.push_back(predicted);
        rand_ticks++;
      end
      phase++;
    end

    settle();
    steady = 1'b0;

    $display("ran %0d ticks and %0d register writes over %0d random phases",
             ticks_sent, writes_done, phase);
    $display("button toggles %0d, step advances %0d, mismatches %0d",
             toggles_seen, advances_seen, mismatch_count);
    if (mismatch_count == 0 && due_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (due_words.size() != 0)
        $display("%0d expected words never arrived", due_words.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
